@@ design/smpq_pkg.sv @@
// shared constants and types for the sorted max-priority queue
`timescale 1ns / 1ps
package smpq_pkg;

  localparam int CAPACITY   = 16;
  localparam int VALUE_BITS = 32;
  localparam int COUNT_BITS = $clog2(CAPACITY + 1);

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0]        count_t;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_POP_EMPTY  = 2'd1,
    STATUS_PUSH_FULL  = 2'd2
  } status_t;

  // command broadcast to every cell
  typedef struct packed {
    logic   push;
    logic   pop;
    value_t value;
  } smpq_cmd_t;

  // handed from a cell to the one behind it
  typedef struct packed {
    logic   keep;
    value_t entry;
  } smpq_link_t;

endpackage

@@ design/smpq_in_if.sv @@
// request channel: operation and value
`timescale 1ns / 1ps
interface smpq_in_if import smpq_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   operation;
  value_t value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

@@ design/smpq_out_if.sv @@
// response channel: top value, flags, count and status
`timescale 1ns / 1ps
interface smpq_out_if import smpq_pkg::*; ();
  logic                  valid;
  logic                  ready;
  value_t                top_value;
  logic                  not_empty;
  logic [COUNT_BITS-1:0] entry_count;
  logic [1:0]            status;

  modport source (output valid, output top_value, output not_empty, output entry_count,
                  output status, input ready);
  modport sink   (input valid, input top_value, input not_empty, input entry_count,
                  input status, output ready);
endinterface

@@ design/smpq_cell.sv @@
// one slot of the sorted queue: holds, loads, or shifts its entry
`timescale 1ns / 1ps
module smpq_cell import smpq_pkg::*; (
  input  logic       clk,
  input  smpq_cmd_t  cmd,
  input  logic       occupied,
  input  smpq_link_t prev_link,
  input  value_t     next_entry,
  output smpq_link_t link
);

  value_t entry;

  always_comb begin
    link.entry = entry;
    link.keep  = occupied && (entry >= cmd.value);
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      if (link.keep) begin
        entry <= entry;
      end else if (prev_link.keep) begin
        entry <= cmd.value;
      end else begin
        entry <= prev_link.entry;
      end
    end else if (cmd.pop) begin
      entry <= next_entry;
    end
  end

endmodule

@@ design/sorted_max_priority_queue.sv @@
// top level of the sorted max-priority queue
//
// req channel carries one transaction per operation: operation selects push
// (insert value) or pop (remove the largest entry). rsp channel returns one
// transaction per request with the largest stored value (zero when empty),
// a not-empty flag, the entry count and a status code.
// entries sit in a row of cells in descending order; a push lets every cell
// compare against the value at once and shift behind the insertion point,
// a pop shifts every cell forward by one. equal values leave in arrival order.
// latency: the response is valid in the cycle after the request transaction.
// throughput: one transaction per cycle while the receiver does not stall rsp;
// the cells themselves hold the response payload.
// pop on empty and push on full change nothing and report an error status.
// reset empties the queue and clears the response valid; entry contents are
// not cleared. while the receiver stalls rsp, req.ready stays low and the
// response holds.
`timescale 1ns / 1ps
module sorted_max_priority_queue import smpq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  smpq_in_if.sink     req,
  smpq_out_if.source  rsp
);

  logic       out_valid;
  count_t     count;
  count_t     count_next;
  status_t    status;
  status_t    status_next;
  logic       accept;
  logic       is_pop;
  logic       is_full;
  logic       is_empty;
  smpq_cmd_t  cmd;

  smpq_link_t links [CAPACITY];
  smpq_link_t head_link;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign is_pop    = (req.operation == OP_POP);
  assign is_full   = (count == count_t'(CAPACITY));
  assign is_empty  = (count == '0);

  always_comb begin
    cmd.value   = req.value;
    cmd.push    = accept && !is_pop && !is_full;
    cmd.pop     = accept && is_pop && !is_empty;
    count_next  = count;
    status_next = STATUS_OK;
    if (is_pop) begin
      if (is_empty) begin
        status_next = STATUS_POP_EMPTY;
      end else begin
        count_next = count - count_t'(1);
      end
    end else begin
      if (is_full) begin
        status_next = STATUS_PUSH_FULL;
      end else begin
        count_next = count + count_t'(1);
      end
    end
  end

  assign head_link.keep  = 1'b1;
  assign head_link.entry = req.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    smpq_link_t prev_link;
    value_t     next_entry;
    if (i == 0) begin : g_first
      assign prev_link = head_link;
    end else begin : g_mid
      assign prev_link = links[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = links[i].entry;
    end else begin : g_inner
      assign next_entry = links[i+1].entry;
    end
    smpq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .occupied   (count > count_t'(i)),
      .prev_link  (prev_link),
      .next_entry (next_entry),
      .link       (links[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      count     <= '0;
      status    <= STATUS_OK;
    end else if (accept) begin
      out_valid <= 1'b1;
      count     <= count_next;
      status    <= status_next;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.top_value   = is_empty ? '0 : links[0].entry;
  assign rsp.not_empty   = !is_empty;
  assign rsp.entry_count = count;
  assign rsp.status      = status;

endmodule

@@ design/smpq_checker.sv @@
// port-level assertions for the sorted max-priority queue, bound to the top level
`timescale 1ns / 1ps
module smpq_assertions import smpq_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  rsp_valid,
  input logic                  rsp_ready,
  input value_t                top_value,
  input logic                  not_empty,
  input logic [COUNT_BITS-1:0] entry_count,
  input logic [1:0]            status
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(top_value) && $stable(entry_count)
      && $stable(status))
    else $error("response changed while stalled");

  a_flag_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (not_empty == (entry_count != '0)))
    else $error("not_empty disagrees with entry_count");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (entry_count <= COUNT_BITS'(CAPACITY)))
    else $error("entry_count above capacity");

  a_empty_top: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !not_empty |-> (top_value == '0))
    else $error("top_value nonzero on empty queue");

  a_error_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((status != STATUS_POP_EMPTY) || (entry_count == '0))
      && ((status != STATUS_PUSH_FULL) || (entry_count == COUNT_BITS'(CAPACITY))))
    else $error("error status with inconsistent count");

endmodule

bind sorted_max_priority_queue smpq_assertions u_smpq_assertions (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .top_value   (rsp.top_value),
  .not_empty   (rsp.not_empty),
  .entry_count (rsp.entry_count),
  .status      (rsp.status)
);

@@ verif/smpq_checker.sv @@
// checker: predicts each response of the priority queue and compares it with the rsp channel
`timescale 1ns / 1ps
module smpq_checker import smpq_pkg::*; (
  input  logic clk,
  input  logic rst,
  smpq_in_if   req,
  smpq_out_if  rsp,
  output int   mismatches,
  output int   awaited
);

  typedef struct packed {
    value_t     top_value;
    logic       not_empty;
    count_t     entry_count;
    logic [1:0] status;
  } queue_report_t;

  value_t        held[$];
  queue_report_t reports_due[$];

  // applies one request to the predicted queue and reports its state afterwards
  function automatic queue_report_t apply_request(op_t op, value_t v);
    queue_report_t r;
    int            pos;
    r.status = STATUS_OK;
    if (op == OP_PUSH) begin
      if (held.size() >= CAPACITY) begin
        r.status = STATUS_PUSH_FULL;
      end else begin
        pos = 0;
        while (pos < held.size() && held[pos] >= v) pos++;
        held.insert(pos, v);
      end
    end else begin
      if (held.size() == 0) begin
        r.status = STATUS_POP_EMPTY;
      end else begin
        void'(held.pop_front());
      end
    end
    r.top_value   = (held.size() > 0) ? held[0] : '0;
    r.not_empty   = (held.size() > 0);
    r.entry_count = count_t'(held.size());
    return r;
  endfunction

  initial begin
    mismatches = 0;
    awaited    = 0;
  end

  always @(posedge clk) begin
    queue_report_t seen;
    queue_report_t want;
    if (rst) begin
      held.delete();
      reports_due.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        seen = '{rsp.top_value, rsp.not_empty, rsp.entry_count, rsp.status};
        if (reports_due.size() == 0) begin
          $display("%0t: unexpected response top %0d not_empty %0b count %0d status %0d",
                   $time, seen.top_value, seen.not_empty, seen.entry_count, seen.status);
          mismatches <= mismatches + 1;
        end else begin
          want = reports_due.pop_front();
          if (seen !== want) begin
            $display("%0t: expected top %0d not_empty %0b count %0d status %0d", $time,
                     want.top_value, want.not_empty, want.entry_count, want.status);
            $display("%0t: actual   top %0d not_empty %0b count %0d status %0d", $time,
                     seen.top_value, seen.not_empty, seen.entry_count, seen.status);
            mismatches <= mismatches + 1;
          end
        end
      end
      if (req.valid && req.ready) begin
        reports_due.push_back(apply_request(op_t'(req.operation), req.value));
      end
    end
    awaited <= reports_due.size();
  end

endmodule

@@ verif/tb_sorted_max_priority_queue.sv @@
// testbench top: drives pushes and pops, paces both channels and gives the verdict
`timescale 1ns / 1ps
module tb_sorted_max_priority_queue;
  import smpq_pkg::*;

  localparam int     RANDOM_ITEMS    = 1423;
  localparam int     HOLD_OFF_CYCLES = 120;
  localparam value_t VALUE_MAX       = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam value_t VALUE_MIN       = {1'b1, {(VALUE_BITS-1){1'b0}}};

  logic clk;
  logic rst;
  int   mismatches;
  int   awaited;
  int   hold_offs_asked = 0;
  int   hold_offs_done  = 0;
  int   burst_left      = 0;

  smpq_in_if  req_ch ();
  smpq_out_if rsp_ch ();

  sorted_max_priority_queue i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  smpq_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic value_t pick_value();
    case ($urandom_range(0, 5))
      0, 1, 2: return value_t'($urandom);
      3, 4:    return value_t'(int'($urandom_range(0, 8)) - 4);
      default: begin
        case ($urandom_range(0, 3))
          0:       return VALUE_MAX;
          1:       return VALUE_MIN;
          2:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // holds the transaction on req until it is accepted
  task automatic send_item(op_t op, value_t v);
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.value     <= v;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  task automatic pace_sender(bit no_gaps);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) < 4 || no_gaps) ? 0 : $urandom_range(1, 7);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic wait_all_responses();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
  endtask

  // receiver: long hold-offs on request, otherwise a changing stall pattern
  initial begin
    int mode;
    int mode_left;
    int cyc;
    mode      = 0;
    mode_left = 0;
    cyc       = 0;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_offs_asked != hold_offs_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_offs_done++;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(16, 200);
        end
        case (mode)
          0:       rsp_ch.ready <= 1'b1;
          1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
          2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
          default: rsp_ch.ready <= (cyc % 5 != 0) && (cyc % 7 != 3);
        endcase
        mode_left--;
        cyc++;
        @(posedge clk);
      end
    end
  end

  initial begin
    int   sent;
    int   phase_no;
    int   phase_len;
    int   push_pct;
    bit   no_gaps;
    op_t  op;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= OP_PUSH;
    req_ch.value     <= '0;
    @(posedge clk);
    while (rst) @(posedge clk);

    // pop on empty, extremes in and out, then a queue full of equal values
    send_item(OP_POP, VALUE_MAX);
    send_item(OP_PUSH, VALUE_MIN);
    send_item(OP_PUSH, VALUE_MAX);
    send_item(OP_PUSH, '0);
    send_item(OP_PUSH, '1);
    repeat (4) send_item(OP_POP, '0);
    send_item(OP_POP, VALUE_MIN);
    repeat (CAPACITY) send_item(OP_PUSH, -5);
    send_item(OP_PUSH, VALUE_MAX);
    wait_all_responses();

    sent     = 0;
    phase_no = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       push_pct = 85;
        1:       push_pct = 15;
        2:       push_pct = 50;
        default: push_pct = 65;
      endcase
      phase_len = $urandom_range(8, 60);
      no_gaps   = ($urandom_range(0, 4) == 0);
      if (phase_no % 7 == 1) hold_offs_asked++;
      for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
        op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        pace_sender(no_gaps);
        send_item(op, pick_value());
        sent++;
      end
      if (phase_no % 5 == 4) wait_all_responses();
      phase_no++;
    end

    wait_all_responses();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
